[sv/char_lcd_buffer_refresh_macros.svh]
// Assertion macros used by the clr_ctrl module of the character LCD buffer.
// Each macro expects aclk and aresetn to exist in the module that uses it.
`ifndef CHAR_LCD_BUFFER_REFRESH_MACROS_SVH
`define CHAR_LCD_BUFFER_REFRESH_MACROS_SVH
`ifndef SYNTHESIS
`define CLR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLR_ASSERT_IMPL(lbl, ante, cons, msg)
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/clr_pkg.sv]
// Shared types, codes and constants of the character LCD buffer refresh block.
// No dependencies.
package clr_pkg;

    localparam int DEFAULT_COLUMNS = 16;
    localparam int DEFAULT_ROWS    = 2;

    // Request kinds carried on s_tuser.
    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_SETPOS = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // Set DDRAM address command of the LCD controller.
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HOME = 4'b0010,
        PH_LINE = 4'b0100,
        PH_DATA = 4'b1000
    } phase_t;

    // Result of one accepted tick, before the screen store data is known.
    typedef struct packed {
        logic       valid;
        logic       is_data;
        logic       from_store;
        logic [7:0] cmd_byte;
    } emit_t;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        case (row)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h14;
            default: off = 8'h54;
        endcase
        return off;
    endfunction

endpackage

[sv/clr_store.sv]
// Screen store: synchronous memory with a registered read and per-entry valid bits.
// Depends on clr_pkg for the default screen size.
module clr_store #(
    parameter int  COLUMNS = clr_pkg::DEFAULT_COLUMNS,
    parameter int  ROWS    = clr_pkg::DEFAULT_ROWS,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [7:0]            wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [7:0]            rd_byte
);
    logic [7:0]       mem [CELLS];
    logic [CELLS-1:0] vld_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A cell that was never written reads as the reset value, zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_byte = rd_vld_reg ? rd_data_reg : 8'h00;

endmodule

[sv/clr_ctrl.sv]
// Request decoder, write position and refresh sequencer.
// Depends on clr_pkg and the assertion macro header.
`include "char_lcd_buffer_refresh_macros.svh"
module clr_ctrl #(
    parameter int  COLUMNS = clr_pkg::DEFAULT_COLUMNS,
    parameter int  ROWS    = clr_pkg::DEFAULT_ROWS,
    localparam int CELLS   = COLUMNS * ROWS,
    localparam int IDX_W   = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic [1:0]         req_type,
    input  logic [7:0]         char_byte,
    input  logic [3:0]         pos_col,
    input  logic [1:0]         pos_row,
    output logic               wr_en,
    output logic [IDX_W-1:0]   wr_addr,
    output logic [7:0]         wr_data,
    output logic               rd_en,
    output logic [IDX_W-1:0]   rd_addr,
    output clr_pkg::emit_t     emit
);
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    clr_pkg::phase_t   phase_reg, phase_next;
    logic              pending_reg, pending_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  show_idx_reg, show_idx_next;
    logic [COL_W-1:0]  show_col_reg, show_col_next;
    logic [1:0]        show_row_reg, show_row_next;

    always_comb begin
        phase_next    = phase_reg;
        pending_next  = pending_reg;
        wr_idx_next   = wr_idx_reg;
        show_idx_next = show_idx_reg;
        show_col_next = show_col_reg;
        show_row_next = show_row_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        emit          = '0;
        if (accept) begin
            case (req_type)
                clr_pkg::REQ_WRITE: begin
                    wr_en        = 1'b1;
                    pending_next = 1'b1;
                    if (wr_idx_reg == IDX_W'(CELLS - 1)) begin
                        wr_idx_next = '0;
                    end else begin
                        wr_idx_next = wr_idx_reg + 1'b1;
                    end
                end
                clr_pkg::REQ_SETPOS: begin
                    if ((int'(pos_col) < COLUMNS) && (int'(pos_row) < ROWS)) begin
                        wr_idx_next = IDX_W'(int'(pos_col) + int'(pos_row) * COLUMNS);
                    end
                end
                clr_pkg::REQ_TICK: begin
                    case (phase_reg)
                        clr_pkg::PH_IDLE: begin
                            if (pending_reg) begin
                                pending_next = 1'b0;
                                phase_next   = clr_pkg::PH_HOME;
                            end
                        end
                        clr_pkg::PH_HOME: begin
                            show_idx_next = '0;
                            show_col_next = '0;
                            show_row_next = '0;
                            emit.valid    = 1'b1;
                            emit.cmd_byte = clr_pkg::CMD_SET_DDRAM;
                            phase_next    = clr_pkg::PH_LINE;
                        end
                        clr_pkg::PH_LINE: begin
                            // A cursor command goes out only at the first column of a line.
                            if (show_col_reg == '0) begin
                                emit.valid    = 1'b1;
                                emit.cmd_byte = clr_pkg::CMD_SET_DDRAM
                                              + clr_pkg::row_offset(show_row_reg);
                            end
                            phase_next = clr_pkg::PH_DATA;
                        end
                        clr_pkg::PH_DATA: begin
                            rd_en           = 1'b1;
                            emit.valid      = 1'b1;
                            emit.is_data    = 1'b1;
                            emit.from_store = 1'b1;
                            if (show_idx_reg == IDX_W'(CELLS - 1)) begin
                                show_idx_next = '0;
                                show_col_next = '0;
                                show_row_next = '0;
                                phase_next    = clr_pkg::PH_IDLE;
                            end else begin
                                show_idx_next = show_idx_reg + 1'b1;
                                if (show_col_reg == COL_W'(COLUMNS - 1)) begin
                                    show_col_next = '0;
                                    show_row_next = show_row_reg + 1'b1;
                                end else begin
                                    show_col_next = show_col_reg + 1'b1;
                                end
                                phase_next = clr_pkg::PH_LINE;
                            end
                        end
                        default: begin
                            phase_next = clr_pkg::PH_IDLE;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign wr_addr = wr_idx_reg;
    assign wr_data = char_byte;
    assign rd_addr = show_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= clr_pkg::PH_IDLE;
            pending_reg  <= 1'b0;
            wr_idx_reg   <= '0;
            show_idx_reg <= '0;
            show_col_reg <= '0;
            show_row_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            wr_idx_reg   <= wr_idx_next;
            show_idx_reg <= show_idx_next;
            show_col_reg <= show_col_next;
            show_row_reg <= show_row_next;
        end
    end

    `CLR_ASSERT_IMPL(a_idx_range, 1'b1,
        (int'(wr_idx_reg) < CELLS) && (int'(show_idx_reg) < CELLS),
        "clr_ctrl: index beyond screen store")
    `CLR_ASSERT_IMPL(a_row_range, 1'b1, int'(show_row_reg) < ROWS,
        "clr_ctrl: refresh row beyond screen")
    `CLR_ASSERT_NEXT(a_home_start, accept && (req_type == clr_pkg::REQ_TICK)
        && (phase_reg == clr_pkg::PH_HOME),
        (show_idx_reg == '0) && (phase_reg == clr_pkg::PH_LINE),
        "clr_ctrl: home step did not restart the scan")
    `CLR_ASSERT_NEXT(a_data_next, accept && (req_type == clr_pkg::REQ_TICK)
        && (phase_reg == clr_pkg::PH_DATA),
        (phase_reg == clr_pkg::PH_LINE) || (phase_reg == clr_pkg::PH_IDLE),
        "clr_ctrl: data step left to a wrong phase")
    `CLR_ASSERT_IMPL(a_store_read, emit.from_store, rd_en && emit.valid && emit.is_data,
        "clr_ctrl: data result without a store read")

endmodule

[sv/clr_out.sv]
// Result stage that merges the store read data, followed by the output register.
// Depends on clr_pkg.
module clr_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  clr_pkg::emit_t  emit,
    input  logic [7:0]      rd_byte,
    output logic            in_ready,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic            m_tuser,
    output logic [7:0]      m_tdata
);
    logic       s1_vld_reg;
    logic       s1_is_data_reg;
    logic       s1_from_store_reg;
    logic [7:0] s1_cmd_reg;
    logic       out_vld_reg;
    logic       out_is_data_reg;
    logic [7:0] out_byte_reg;
    logic       out_free;
    logic       s1_adv;

    assign out_free = !out_vld_reg || m_tready;
    assign s1_adv   = s1_vld_reg && out_free;
    // The store read register only changes on an accepted item, so it holds while stalled.
    assign in_ready = !s1_vld_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_vld_reg <= emit.valid;
            end
            if (out_free) begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            s1_is_data_reg    <= emit.is_data;
            s1_from_store_reg <= emit.from_store;
            s1_cmd_reg        <= emit.cmd_byte;
        end
        if (s1_adv) begin
            out_is_data_reg <= s1_is_data_reg;
            out_byte_reg    <= s1_from_store_reg ? rd_byte : s1_cmd_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_is_data_reg;
    assign m_tdata  = out_byte_reg;

endmodule

[sv/char_lcd_buffer_refresh.sv]
// Character LCD screen buffer with refresh sequencer. One item is accepted per
// clock cycle; s_tready drops only when both result registers hold a byte and
// m_tready is low. An emitting tick passes its byte through the result stage register,
// which takes a data byte from the synchronous read of the screen store, and then the
// output register. A full refresh takes 2 + 2*COLUMNS*ROWS ticks (one to start,
// the home command, then a cursor-or-empty tick and a data tick for each cell).
// The store comes out of reset reading all zeros through per-cell valid bits,
// with no clearing pass.
module char_lcd_buffer_refresh #(
    parameter int COLUMNS = clr_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = clr_pkg::DEFAULT_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_byte[7:0], pos_col[11:8], pos_row[13:12], zero
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // lcd_byte
    output logic        m_tuser    // is_data
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic             in_ready;
    logic             accept;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_byte;
    clr_pkg::emit_t   emit;

    assign s_tready = in_ready;
    assign accept   = s_tvalid && in_ready;

    clr_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .req_type  (s_tuser),
        .char_byte (s_tdata[7:0]),
        .pos_col   (s_tdata[11:8]),
        .pos_row   (s_tdata[13:12]),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .emit      (emit)
    );

    clr_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_byte (rd_byte)
    );

    clr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .emit     (emit),
        .rd_byte  (rd_byte),
        .in_ready (in_ready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule
